FILE: src/bda_pkg.sv
// shared types, constants and status codes of the deadlock avoider
`default_nettype none
package bda_pkg;
   localparam int PROCESSES_DEF      = 8;
   localparam int RESOURCE_TYPES_DEF = 4;
   localparam int MAX_PROC           = 8;
   localparam int MAX_RES            = 4;
   localparam int UNIT_W             = 8;
   localparam int WORK_W             = 12;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_STAGE  = 2'd1,
      CMD_COMMIT = 2'd2,
      CMD_CHECK  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EXCEEDS = 3'd1,
      ST_WAIT    = 3'd2,
      ST_UNSAFE  = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type      command;
      logic [2:0]   process;
      logic [1:0]   resource;
      logic [7:0]   amount;
      logic [7:0]   claim;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] seq_process;
      logic       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;      // capture the item
      logic       do_load;    // apply load (checks inside)
      logic       do_stage;
      logic       apply;      // add staged request to entry
      logic       rollback;   // subtract staged request
      logic       scan_init;  // load work vector with available units, clear done flags
      logic       scan_step;  // test one process
      logic [2:0] scan_proc;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic       load_ok;
      logic       claim_ok;
      logic       avail_ok;
      logic       fits;       // scanned process fits and not done
      logic       proc_ok;
   } sts_type;
endpackage
`default_nettype wire

FILE: src/bda_if.sv
// valid/ready channel interface
`default_nettype none
interface bda_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/bda_datapath.sv
// tables, held sums, staged vector and safety scan work vector
`default_nettype none
module bda_datapath #(
   parameter int PROCESSES      = bda_pkg::PROCESSES_DEF,
   parameter int RESOURCE_TYPES = bda_pkg::RESOURCE_TYPES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bda_pkg::req_type  item,
   input  wire logic [31:0]       totals,
   input  wire bda_pkg::ctl_type  ctl,
   output bda_pkg::sts_type       sts
);
   localparam int W = bda_pkg::WORK_W;
   logic [7:0] held_ff [bda_pkg::MAX_PROC][bda_pkg::MAX_RES];
   logic [7:0] need_ff [bda_pkg::MAX_PROC][bda_pkg::MAX_RES];
   logic [7:0] sum_ff [bda_pkg::MAX_RES];
   logic [7:0] stg_ff [bda_pkg::MAX_RES];
   logic signed [W-1:0] work_ff [bda_pkg::MAX_RES];
   logic [bda_pkg::MAX_PROC-1:0] done_ff;
   bda_pkg::req_type it_ff;

   logic [2:0] pi, sp;
   logic [1:0] ri;
   logic       pv, rv;
   logic [8:0] newsum;
   logic       fits_c;

   assign pi = it_ff.process;
   assign ri = it_ff.resource;
   assign pv = 32'(pi) < PROCESSES;
   assign rv = 32'(ri) < RESOURCE_TYPES;
   assign sp = ctl.scan_proc;

   function automatic logic signed [W-1:0] avail(input logic [7:0] t, input logic [7:0] s);
      return W'($signed({1'b0, t})) - W'($signed({1'b0, s}));
   endfunction

   always_comb begin
      logic [7:0] h;
      logic [7:0] t;
      h = 8'd0;
      t = totals[8*ri +: 8];
      newsum = 9'd0;
      sts.load_ok = 1'b0;
      if (pv && rv) begin
         h = held_ff[pi][ri];
         newsum = {1'b0, sum_ff[ri]} - {1'b0, h} + {1'b0, it_ff.amount};
         sts.load_ok = (it_ff.amount <= it_ff.claim) && (newsum <= {1'b0, t});
      end
      sts.proc_ok = pv;
      sts.claim_ok = 1'b1;
      sts.avail_ok = 1'b1;
      fits_c = !done_ff[sp];
      for (int r = 0; r < RESOURCE_TYPES; r++) begin
         if (pv && stg_ff[r] > need_ff[pi][r]) sts.claim_ok = 1'b0;
         if ($signed({4'd0, stg_ff[r]}) > avail(totals[8*r +: 8], sum_ff[r]))
            sts.avail_ok = 1'b0;
         if ($signed({4'd0, need_ff[sp][r]}) > work_ff[r]) fits_c = 1'b0;
      end
      sts.fits = fits_c;
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) it_ff <= item;
      if (ctl.do_load && sts.load_ok) begin
         held_ff[pi][ri] <= it_ff.amount;
         need_ff[pi][ri] <= it_ff.claim - it_ff.amount;
         sum_ff[ri] <= newsum[7:0];
      end
      if (ctl.do_stage && rv) stg_ff[ri] <= it_ff.amount;
      for (int r = 0; r < RESOURCE_TYPES; r++) begin
         if (ctl.apply) begin
            sum_ff[r] <= sum_ff[r] + stg_ff[r];
            held_ff[pi][r] <= held_ff[pi][r] + stg_ff[r];
            need_ff[pi][r] <= need_ff[pi][r] - stg_ff[r];
         end
         if (ctl.rollback) begin
            sum_ff[r] <= sum_ff[r] - stg_ff[r];
            held_ff[pi][r] <= held_ff[pi][r] - stg_ff[r];
            need_ff[pi][r] <= need_ff[pi][r] + stg_ff[r];
         end
         if (ctl.scan_init) work_ff[r] <= avail(totals[8*r +: 8], sum_ff[r]);
         else if (ctl.scan_step && fits_c)
            work_ff[r] <= work_ff[r] + W'($signed({1'b0, held_ff[sp][r]}));
      end
      if (ctl.scan_init) done_ff <= '0;
      else if (ctl.scan_step && fits_c) done_ff[sp] <= 1'b1;
      if (reset) begin
         for (int p = 0; p < bda_pkg::MAX_PROC; p++)
            for (int r = 0; r < bda_pkg::MAX_RES; r++) begin
               held_ff[p][r] <= 8'd0;
               need_ff[p][r] <= 8'd0;
            end
         for (int r = 0; r < bda_pkg::MAX_RES; r++) begin
            sum_ff[r] <= 8'd0;
            stg_ff[r] <= 8'd0;
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/bda_controller.sv
// command sequencer, safety scan walker and result emitter
`default_nettype none
module bda_controller #(
   parameter int PROCESSES = bda_pkg::PROCESSES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bda_pkg::cmd_type  req_command,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bda_pkg::rsp_type       rsp_data,
   output bda_pkg::ctl_type       ctl,
   input  wire bda_pkg::sts_type  sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SCAN_INIT, S_SCAN, S_DECIDE, S_RESP, S_EMIT
   } state_type;

   state_type       state_ff;
   bda_pkg::cmd_type cmd_ff;
   logic [2:0]      proc_ff, count_ff, emit_ff;
   logic            prog_ff;
   logic [2:0]      order_ff [bda_pkg::MAX_PROC];
   logic            safe_ff;
   bda_pkg::rsp_type res_ff;   // single result waiting for the output register
   bda_pkg::rsp_type out_ff;
   logic            ov_ff;

   always_comb begin
      ctl = '0;
      ctl.latch     = state_ff == S_IDLE && req_valid;
      ctl.do_load   = state_ff == S_EXEC && cmd_ff == bda_pkg::CMD_LOAD;
      ctl.do_stage  = state_ff == S_EXEC && cmd_ff == bda_pkg::CMD_STAGE;
      ctl.apply     = state_ff == S_EXEC && cmd_ff == bda_pkg::CMD_COMMIT
                      && sts.proc_ok && sts.claim_ok && sts.avail_ok;
      ctl.scan_init = state_ff == S_SCAN_INIT;
      ctl.scan_step = state_ff == S_SCAN;
      ctl.scan_proc = proc_ff;
      ctl.rollback  = state_ff == S_DECIDE && cmd_ff == bda_pkg::CMD_COMMIT && !safe_ff;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (ov_ff && rsp_ready) ov_ff <= 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_ff <= req_command;
               state_ff <= S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff)
               bda_pkg::CMD_LOAD: begin
                  res_ff <= {sts.load_ok ? bda_pkg::ST_OK : bda_pkg::ST_INVALID, 3'd0, 1'b1};
                  state_ff <= S_RESP;
               end
               bda_pkg::CMD_STAGE: begin
                  res_ff <= {bda_pkg::ST_OK, 3'd0, 1'b1};
                  state_ff <= S_RESP;
               end
               bda_pkg::CMD_COMMIT: begin
                  if (!sts.proc_ok || !sts.claim_ok) begin
                     res_ff <= {bda_pkg::ST_EXCEEDS, 3'd0, 1'b1};
                     state_ff <= S_RESP;
                  end else if (!sts.avail_ok) begin
                     res_ff <= {bda_pkg::ST_WAIT, 3'd0, 1'b1};
                     state_ff <= S_RESP;
                  end else state_ff <= S_SCAN_INIT;
               end
               default: state_ff <= S_SCAN_INIT;
            endcase
         end
         S_SCAN_INIT: begin
            proc_ff <= 3'd0;
            count_ff <= 3'd0;
            prog_ff <= 1'b0;
            safe_ff <= 1'b0;
            state_ff <= S_SCAN;
         end
         S_SCAN: begin
            if (sts.fits) begin
               order_ff[count_ff] <= proc_ff;
               count_ff <= count_ff + 3'd1;
            end
            if (sts.fits && 32'(count_ff) == PROCESSES - 1) begin
               safe_ff <= 1'b1;
               state_ff <= S_DECIDE;
            end else if (32'(proc_ff) == PROCESSES - 1) begin
               proc_ff <= 3'd0;
               prog_ff <= 1'b0;
               if (!(prog_ff || sts.fits)) state_ff <= S_DECIDE;
            end else begin
               proc_ff <= proc_ff + 3'd1;
               if (sts.fits) prog_ff <= 1'b1;
            end
         end
         S_DECIDE: begin
            emit_ff <= 3'd0;
            if (cmd_ff == bda_pkg::CMD_COMMIT) begin
               res_ff <= {safe_ff ? bda_pkg::ST_OK : bda_pkg::ST_UNSAFE, 3'd0, 1'b1};
               state_ff <= S_RESP;
            end else if (!safe_ff) begin
               res_ff <= {bda_pkg::ST_UNSAFE, 3'd0, 1'b1};
               state_ff <= S_RESP;
            end else state_ff <= S_EMIT;
         end
         S_RESP: begin
            if (!ov_ff || rsp_ready) begin
               ov_ff <= 1'b1;
               out_ff <= res_ff;
               state_ff <= S_IDLE;
            end
         end
         S_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               ov_ff <= 1'b1;
               out_ff <= {bda_pkg::ST_OK, order_ff[emit_ff],
                          32'(emit_ff) == PROCESSES - 1};
               emit_ff <= emit_ff + 3'd1;
               if (32'(emit_ff) == PROCESSES - 1) state_ff <= S_IDLE;
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

FILE: src/bankers_deadlock_avoider_core.sv
// top level of the banker's algorithm deadlock avoider
// One item at a time. Load, stage and a rejected commit pass from S_IDLE through
// S_EXEC and S_RESP back to S_IDLE. An accepted commit
// and a check run the safety scan, one process tested per cycle, up to PROCESSES
// passes over the processes, through S_SCAN_INIT, S_SCAN and S_DECIDE.
// A safe check then delivers PROCESSES result items, one per cycle when taken,
// before the next item is taken. A result register decouples the result side;
// a new item is taken once the previous one has placed its last result in that
// register, and a finished item waits while the register still holds an untaken result.
`default_nettype none
module bankers_deadlock_avoider_core #(
   parameter int PROCESSES      = bda_pkg::PROCESSES_DEF,
   parameter int RESOURCE_TYPES = bda_pkg::RESOURCE_TYPES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bda_if.sink              req,
   bda_if.source            rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);
   // configured totals, one byte per resource
   logic [31:0] totals_ff;
   bda_pkg::ctl_type ctl;
   bda_pkg::sts_type sts;
   bda_pkg::req_type item;
   bda_pkg::rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (csr_write_enable) totals_ff[8*csr_index +: 8] <= csr_write_data;
      if (reset) totals_ff <= '0;
   end

   assign item = req.payload;
   assign rsp.payload = rsp_data;

   bda_controller #(.PROCESSES(PROCESSES)) u_ctl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_command(item.command),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data,
      .ctl, .sts
   );

   bda_datapath #(.PROCESSES(PROCESSES), .RESOURCE_TYPES(RESOURCE_TYPES)) u_dp (
      .clock, .reset, .item, .totals(totals_ff), .ctl, .sts
   );

`ifndef SYNTHESIS
   // apply and rollback never in the same cycle
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.apply && ctl.rollback)) else $error("apply and rollback together");
   // no new item taken during a scan
   a_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.scan_step |-> !req.ready) else $error("ready during scan");
   // each accepted item is latched next cycle into execution
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("ready held after accept");
`endif
endmodule
`default_nettype wire
